FILE: rtl/core/rational_arithmetic_unit_assert.svh
// Assertion macros for the checker file of the rational arithmetic unit.
// Each macro expects clk and arst_n in scope.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int PROD_W = 64;
	localparam int SHIFT_W = 6;

	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_INC = 3'd4;
	localparam logic [2:0] ACT_DEC = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;
	localparam logic [1:0] ST_OVFL = 2'd3;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

FILE: rtl/core/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider
// Restoring divider, one quotient bit per cycle over the product width.
// ----------------------------------------------------------------------------
module rau_divider (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rau_pkg::div_ctl_t                ctl,
	input  logic [rau_pkg::PROD_W-1:0]       dividend,
	input  logic [rau_pkg::PROD_W-1:0]       divisor,
	output rau_pkg::div_sts_t                sts,
	output logic [rau_pkg::PROD_W-1:0]       quotient
);

	logic [rau_pkg::PROD_W-1:0]  dvd_q;
	logic [rau_pkg::PROD_W-1:0]  rem_q;
	logic [rau_pkg::PROD_W-1:0]  dsr_q;
	logic [rau_pkg::SHIFT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [rau_pkg::PROD_W:0]    trial;
	logic                        fits;

	assign trial = {rem_q, dvd_q[rau_pkg::PROD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= rau_pkg::SHIFT_W'(rau_pkg::PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rau_pkg::PROD_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[rau_pkg::PROD_W-1:0];
			end
			dvd_q <= {dvd_q[rau_pkg::PROD_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = dvd_q;

endmodule

FILE: rtl/core/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Signed fraction add/sub/mul/div/inc/dec with gcd reduction.
// ----------------------------------------------------------------------------
// One item at a time. After an item is accepted the unit runs three passes
// of a shared 32x32 multiplier, one sign-magnitude add, a binary gcd with
// one shift or subtract per cycle, two passes of a restoring divider that
// divides numerator and denominator by the gcd, an overflow check and a
// load of the output register. Items that fail the zero denominator or
// division by zero test go straight to the output load, and results whose
// numerator is zero skip the gcd, the divider and the overflow check.
// in_stall is high from acceptance until the result has been moved to the
// output register.
// Errors return 0/1; WIDTH sets only the overflow limit.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] left_numerator,
	input  logic signed [31:0] left_denominator,
	input  logic signed [31:0] right_numerator,
	input  logic signed [31:0] right_denominator,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_numerator,
	output logic [30:0]        result_denominator,
	output logic [1:0]         status
);

	localparam int PW = rau_pkg::PROD_W;
	localparam logic [PW-1:0] LIM = PW'(1) << (WIDTH - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_ADD, S_GCD, S_DIVN, S_DIVD, S_CHK, S_DONE
	} state_t;

	state_t state_q;

	// operand magnitudes and signs
	logic [31:0] ln_m_q, ld_m_q, rn_m_q, rd_m_q;
	logic        ln_s_q, ld_s_q, rn_s_q, rd_s_q;
	logic [2:0]  act_q;
	logic [1:0]  mstep_q;

	logic [PW-1:0] p0_q, p1_q, den_q;
	logic [PW-1:0] u_q, v_q, nm_q;
	logic [rau_pkg::SHIFT_W-1:0] k_q;
	logic          neg_q;

	logic signed [31:0] res_num_q;
	logic [30:0]        res_den_q;
	logic [1:0]         res_st_q;

	logic               out_valid_q;
	logic signed [31:0] out_num_q;
	logic [30:0]        out_den_q;
	logic [1:0]         out_st_q;

	// input magnitudes (a negated minimum still fits 32 unsigned bits)
	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (32'd0 - x) : x;
	endfunction

	// shared multiplier operand select
	logic [31:0]  mul_a, mul_b;
	logic [PW-1:0] mul_p;
	logic          act_lr, act_id;

	assign act_lr = (act_q == rau_pkg::ACT_ADD) || (act_q == rau_pkg::ACT_SUB);
	assign act_id = (act_q == rau_pkg::ACT_INC) || (act_q == rau_pkg::ACT_DEC);

	always_comb begin
		mul_a = ld_m_q;
		mul_b = 32'd1;
		case (mstep_q)
			2'd0: begin
				mul_a = ln_m_q;
				if (act_lr || act_q == rau_pkg::ACT_DIV) mul_b = rd_m_q;
				else if (act_q == rau_pkg::ACT_MUL) mul_b = rn_m_q;
			end
			2'd1: begin
				mul_a = act_lr ? rn_m_q : (act_id ? ld_m_q : 32'd0);
				mul_b = act_lr ? ld_m_q : 32'd1;
			end
			default: begin
				mul_a = ld_m_q;
				if (act_lr || act_q == rau_pkg::ACT_MUL) mul_b = rd_m_q;
				else if (act_q == rau_pkg::ACT_DIV) mul_b = rn_m_q;
			end
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// sign-magnitude add of the two numerator terms
	logic          s0, s1, sd;
	logic [PW-1:0] sum_m;
	logic          sum_s;

	always_comb begin
		s0 = ln_s_q;
		s1 = ld_s_q;
		sd = ld_s_q;
		case (act_q)
			rau_pkg::ACT_ADD: begin s0 = ln_s_q ^ rd_s_q; s1 = rn_s_q ^ ld_s_q; sd = ld_s_q ^ rd_s_q; end
			rau_pkg::ACT_SUB: begin s0 = ln_s_q ^ rd_s_q; s1 = ~(rn_s_q ^ ld_s_q); sd = ld_s_q ^ rd_s_q; end
			rau_pkg::ACT_MUL: begin s0 = ln_s_q ^ rn_s_q; sd = ld_s_q ^ rd_s_q; end
			rau_pkg::ACT_DIV: begin s0 = ln_s_q ^ rd_s_q; sd = ld_s_q ^ rn_s_q; end
			rau_pkg::ACT_DEC: s1 = ~ld_s_q;
			default: ;
		endcase
		if (s0 == s1) begin
			sum_m = p0_q + p1_q;
			sum_s = s0;
		end else if (p0_q >= p1_q) begin
			sum_m = p0_q - p1_q;
			sum_s = s0;
		end else begin
			sum_m = p1_q - p0_q;
			sum_s = s1;
		end
	end

	// divider: numerator pass, then denominator pass, both by the gcd
	rau_pkg::div_ctl_t div_ctl;
	rau_pkg::div_sts_t div_sts;
	logic [PW-1:0]     div_q;
	logic [PW-1:0]     gcd_v;

	assign gcd_v = v_q << k_q;
	assign div_ctl.start = ((state_q == S_GCD) && (u_q == '0)) ||
		((state_q == S_DIVN) && div_sts.done);

	rau_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend ((state_q == S_GCD) ? p0_q : den_q),
		.divisor  (gcd_v),
		.sts      (div_sts),
		.quotient (div_q)
	);

	logic zden, divz;
	assign zden = (left_denominator == '0) ||
		((action <= rau_pkg::ACT_DIV) && (right_denominator == '0));
	assign divz = (action == rau_pkg::ACT_DIV) && (right_numerator == '0);

	logic ovfl;
	assign ovfl = (div_q > LIM - 1'b1) || (neg_q ? (nm_q > LIM) : (nm_q > LIM - 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mstep_q     <= '0;
		end else begin
			// S_DONE reloads the output register itself
			if (out_valid_q && !out_stall && (state_q != S_DONE)) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q  <= action;
						ln_m_q <= mag32(left_numerator);
						ld_m_q <= mag32(left_denominator);
						rn_m_q <= mag32(right_numerator);
						rd_m_q <= mag32(right_denominator);
						ln_s_q <= left_numerator[31];
						ld_s_q <= left_denominator[31];
						rn_s_q <= right_numerator[31];
						rd_s_q <= right_denominator[31];
						mstep_q <= '0;
						res_num_q <= '0;
						res_den_q <= 31'd1;
						if (zden) begin
							res_st_q <= rau_pkg::ST_ZDEN;
							state_q  <= S_DONE;
						end else if (divz) begin
							res_st_q <= rau_pkg::ST_DIVZ;
							state_q  <= S_DONE;
						end else begin
							res_st_q <= rau_pkg::ST_OK;
							state_q  <= S_MUL;
						end
					end
				end
				S_MUL: begin
					case (mstep_q)
						2'd0:    p0_q  <= mul_p;
						2'd1:    p1_q  <= mul_p;
						default: den_q <= mul_p;
					endcase
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 2'd2) state_q <= S_ADD;
				end
				S_ADD: begin
					p0_q  <= sum_m;
					neg_q <= sum_s ^ sd;
					u_q   <= sum_m;
					v_q   <= den_q;
					k_q   <= '0;
					// zero numerator keeps the preset 0/1 ok result
					state_q <= (sum_m == '0) ? S_DONE : S_GCD;
				end
				S_GCD: begin
					if (u_q == '0) begin
						state_q <= S_DIVN;
					end else if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (u_q >= v_q) begin
						u_q <= u_q - v_q;
					end else begin
						v_q <= v_q - u_q;
					end
				end
				S_DIVN: begin
					if (div_sts.done) begin
						nm_q    <= div_q;
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (div_sts.done) state_q <= S_CHK;
				end
				S_CHK: begin
					if (ovfl) begin
						res_st_q <= rau_pkg::ST_OVFL;
					end else begin
						res_num_q <= neg_q ? (32'd0 - nm_q[31:0]) : nm_q[31:0];
						res_den_q <= div_q[30:0];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_num_q   <= res_num_q;
						out_den_q   <= res_den_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall           = (state_q != S_IDLE);
	assign out_valid          = out_valid_q;
	assign result_numerator   = out_num_q;
	assign result_denominator = out_den_q;
	assign status             = out_st_q;

endmodule

FILE: rtl/core/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level assertions for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_assert.svh"

module rau_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] result_numerator,
	input logic [30:0]        result_denominator,
	input logic [1:0]         status
);

	`RAU_ASSERT_IMPLY(a_err_zero, out_valid && (status != rau_pkg::ST_OK), (result_numerator == 0) && (result_denominator == 31'd1))
	`RAU_ASSERT_IMPLY(a_den_pos, out_valid && (status == rau_pkg::ST_OK), result_denominator != 31'd0)
	`RAU_ASSERT_IMPLY(a_zero_one, out_valid && (status == rau_pkg::ST_OK) && (result_numerator == 0), result_denominator == 31'd1)
	`RAU_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(result_numerator) && $stable(result_denominator) && $stable(status))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.result_numerator   (result_numerator),
	.result_denominator (result_denominator),
	.status             (status)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rational arithmetic unit.
// ----------------------------------------------------------------------------
// Directed fractions at the field extremes, every action and each error path,
// then random items biased toward small and well-formed fractions. A local
// sign-magnitude predictor computes each expected fraction and status; a
// scoreboard compares results in order. Both sides idle at random, and one
// long output hold-off forces the unit to back up and stall its input.
// ----------------------------------------------------------------------------

// expected-result store and comparator
class frac_scoreboard;
	logic signed [31:0] exp_num_q[$];
	logic [30:0]        exp_den_q[$];
	logic [1:0]         exp_st_q[$];
	int                 errors;
	int                 checked;

	function void note_item(logic signed [31:0] n, logic [30:0] d, logic [1:0] s);
		exp_num_q.push_back(n);
		exp_den_q.push_back(d);
		exp_st_q.push_back(s);
	endfunction

	function void check_result(logic signed [31:0] n, logic [30:0] d, logic [1:0] s);
		logic signed [31:0] en;
		logic [30:0]        ed;
		logic [1:0]         es;
		if (exp_num_q.size() == 0) begin
			$error("result with no item pending: %0d/%0d st %0d", n, d, s);
			errors++;
			return;
		end
		en = exp_num_q.pop_front();
		ed = exp_den_q.pop_front();
		es = exp_st_q.pop_front();
		checked++;
		if (n !== en) begin
			$error("result_numerator expected %0d actual %0d", en, n);
			errors++;
		end
		if (d !== ed) begin
			$error("result_denominator expected %0d actual %0d", ed, d);
			errors++;
		end
		if (s !== es) begin
			$error("status expected %0d actual %0d", es, s);
			errors++;
		end
	endfunction

	function int pending();
		return exp_num_q.size();
	endfunction
endclass

module tb;
	localparam int WIDTH = 32;
	localparam int N_RANDOM = 1280;
	localparam longint CYCLE_LIMIT = 64'd4_000_000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         action;
	logic signed [31:0] left_numerator;
	logic signed [31:0] left_denominator;
	logic signed [31:0] right_numerator;
	logic signed [31:0] right_denominator;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] result_numerator;
	logic [30:0]        result_denominator;
	logic [1:0]         status;

	frac_scoreboard fracs;
	longint cycles;
	int     items_sent;
	int     op_seen[8];
	bit     hold_off;       // long receiver hold-off in progress
	bit     calm;           // no random idling on either side

	rational_arithmetic_unit #(.WIDTH(WIDTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.left_numerator(left_numerator),
		.left_denominator(left_denominator),
		.right_numerator(right_numerator),
		.right_denominator(right_denominator),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_numerator(result_numerator),
		.result_denominator(result_denominator),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---- predictor: sign plus 64-bit magnitude, as the unit computes ----
	typedef struct {
		bit          neg;
		bit [63:0]   mag;
	} smag_t;

	function automatic smag_t to_smag(logic signed [31:0] v);
		smag_t r;
		r.neg = v[31];
		r.mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
		return r;
	endfunction

	function automatic smag_t smag_mul(smag_t a, smag_t b);
		smag_t r;
		r.mag = a.mag * b.mag;
		r.neg = (a.neg != b.neg) && r.mag != 0;
		return r;
	endfunction

	function automatic smag_t smag_flip(smag_t a);
		if (a.mag != 0)
			a.neg = !a.neg;
		return a;
	endfunction

	function automatic smag_t smag_add(smag_t a, smag_t b);
		smag_t r;
		if (a.neg == b.neg) begin
			r.mag = a.mag + b.mag;
			r.neg = a.neg;
		end else if (a.mag >= b.mag) begin
			r.mag = a.mag - b.mag;
			r.neg = a.neg;
		end else begin
			r.mag = b.mag - a.mag;
			r.neg = b.neg;
		end
		if (r.mag == 0)
			r.neg = 1'b0;
		return r;
	endfunction

	function automatic bit [63:0] euclid(bit [63:0] a, bit [63:0] b);
		bit [63:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	task automatic predict_fraction(
		input logic [2:0] op,
		input logic signed [31:0] ln_v, ld_v, rn_v, rd_v,
		output logic signed [31:0] pn, output logic [30:0] pd, output logic [1:0] ps
	);
		smag_t ln, ld, rn, rd, num, den;
		bit [63:0] g, nm, dm, lim;
		bit neg;
		ln = to_smag(ln_v);
		ld = to_smag(ld_v);
		rn = to_smag(rn_v);
		rd = to_smag(rd_v);
		pn = '0;
		pd = 31'd1;
		ps = rau_pkg::ST_OK;
		if (ld.mag == 0 || (op <= rau_pkg::ACT_DIV && rd.mag == 0)) begin
			ps = rau_pkg::ST_ZDEN;
			return;
		end
		if (op == rau_pkg::ACT_DIV && rn.mag == 0) begin
			ps = rau_pkg::ST_DIVZ;
			return;
		end
		case (op)
			rau_pkg::ACT_ADD: begin
				num = smag_add(smag_mul(ln, rd), smag_mul(rn, ld));
				den = smag_mul(ld, rd);
			end
			rau_pkg::ACT_SUB: begin
				num = smag_add(smag_mul(ln, rd), smag_flip(smag_mul(rn, ld)));
				den = smag_mul(ld, rd);
			end
			rau_pkg::ACT_MUL: begin
				num = smag_mul(ln, rn);
				den = smag_mul(ld, rd);
			end
			rau_pkg::ACT_DIV: begin
				num = smag_mul(ln, rd);
				den = smag_mul(ld, rn);
			end
			rau_pkg::ACT_INC: begin
				num = smag_add(ln, ld);
				den = ld;
			end
			rau_pkg::ACT_DEC: begin
				num = smag_add(ln, smag_flip(ld));
				den = ld;
			end
			default: begin
				// unused codes pass the first fraction through, reduced
				num = ln;
				den = ld;
			end
		endcase
		if (num.mag == 0)
			return;
		g = euclid(num.mag, den.mag);
		nm = num.mag / g;
		dm = den.mag / g;
		neg = num.neg != den.neg;
		lim = 64'd1 << (WIDTH - 1);
		if (dm > lim - 1 || (neg ? nm > lim : nm > lim - 1)) begin
			ps = rau_pkg::ST_OVFL;
			return;
		end
		pn = neg ? (32'd0 - nm[31:0]) : nm[31:0];
		pd = dm[30:0];
	endtask

	// ---- stimulus helpers ----
	function automatic logic signed [31:0] pick_value();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0, 1, 2, 3: return $signed($urandom_range(0, 40)) - 20;
			4, 5:       return $signed($urandom_range(0, 2000)) - 1000;
			6:          return $urandom();
			7:          return $signed($urandom_range(0, 65535)) - 32768;
			8:          return {1'b0, 31'h7fff_ffff} - $urandom_range(0, 3);
			default:    return {1'b1, 31'd0} + $urandom_range(0, 3);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_denominator();
		logic signed [31:0] v;
		// an occasional zero reaches the zero-denominator path
		if ($urandom_range(0, 39) == 0)
			return '0;
		v = pick_value();
		return (v == 0) ? 32'sd1 : v;
	endfunction

	// offer one item and wait until it is taken; inputs move on the falling edge
	task automatic send_item(
		input logic [2:0] op,
		input logic signed [31:0] ln_v, ld_v, rn_v, rd_v
	);
		logic signed [31:0] pn;
		logic [30:0] pd;
		logic [1:0] ps;
		if (!calm)
			while ($urandom_range(0, 99) < 29) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		action            <= op;
		left_numerator    <= ln_v;
		left_denominator  <= ld_v;
		right_numerator   <= rn_v;
		right_denominator <= rd_v;
		in_valid          <= 1'b1;
		predict_fraction(op, ln_v, ld_v, rn_v, rd_v, pn, pd, ps);
		do
			@(posedge clk);
		while (in_stall);
		fracs.note_item(pn, pd, ps);
		items_sent++;
		op_seen[op]++;
		@(negedge clk);
	endtask

	// output side: random stall, sample at the rising edge
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off)
				out_stall <= 1'b1;
			else if (calm)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 99) < 29);
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			fracs.check_result(result_numerator, result_denominator, status);

	// long receiver hold-off, counted in its own process
	initial begin
		int n;
		hold_off = 1'b0;
		wait (items_sent >= 300);
		@(negedge clk);
		hold_off = 1'b1;
		for (n = 0; n < 2000; n++)
			@(negedge clk);
		hold_off = 1'b0;
	end

	// cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results pending",
					cycles, fracs.pending());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int k;
		logic [2:0] op;
		logic signed [31:0] a, b, c, d;
		fracs = new();
		calm = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = rau_pkg::ACT_ADD;
		left_numerator = '0;
		left_denominator = 32'sd1;
		right_numerator = '0;
		right_denominator = 32'sd1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: each action, error paths, field extremes
		send_item(rau_pkg::ACT_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
		send_item(rau_pkg::ACT_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2);     // zero gives 0/1
		send_item(rau_pkg::ACT_MUL, -32'sd4, 32'sd6, 32'sd3, -32'sd8);
		send_item(rau_pkg::ACT_DIV, 32'sd3, 32'sd7, -32'sd9, 32'sd14);
		send_item(rau_pkg::ACT_INC, 32'sd5, -32'sd3, 32'sd0, 32'sd0);    // right ignored
		send_item(rau_pkg::ACT_DEC, -32'sd7, 32'sd2, 32'sd0, 32'sd0);
		send_item(rau_pkg::ACT_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd1);     // zero left den
		send_item(rau_pkg::ACT_MUL, 32'sd1, 32'sd1, 32'sd1, 32'sd0);     // zero right den
		send_item(rau_pkg::ACT_DIV, 32'sd1, 32'sd1, 32'sd0, 32'sd0);     // zero den wins
		send_item(rau_pkg::ACT_DIV, 32'sd5, 32'sd1, 32'sd0, 32'sd3);     // divide by zero
		send_item(3'd6, 32'sd12, -32'sd18, 32'sd0, 32'sd0);              // unused code
		send_item(3'd7, 32'sh8000_0000, 32'sd1, 32'sd0, 32'sd0);
		send_item(3'd6, 32'sh8000_0000, -32'sd1, 32'sd0, 32'sd0);        // +2^31 overflows
		send_item(rau_pkg::ACT_MUL, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff);
		send_item(rau_pkg::ACT_ADD, 32'sh7fff_ffff, 32'sd1, 32'sh7fff_ffff, 32'sd1);
		send_item(rau_pkg::ACT_SUB, 32'sh8000_0000, 32'sd1, 32'sd1, 32'sd1);
		send_item(rau_pkg::ACT_ADD, 32'sd1, 32'sh7fff_ffff, 32'sd1, 32'sh7fff_fffe);
		send_item(rau_pkg::ACT_DIV, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000);
		send_item(rau_pkg::ACT_INC, 32'sh7fff_ffff, 32'sd1, 32'sd0, 32'sd0);
		send_item(rau_pkg::ACT_DEC, 32'sh8000_0000, 32'sd1, 32'sd0, 32'sd0);
		send_item(rau_pkg::ACT_DEC, 32'sd0, 32'sh8000_0000, 32'sd0, 32'sd0);
		send_item(rau_pkg::ACT_DIV, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
		send_item(rau_pkg::ACT_INC, 32'sd0, 32'sh8000_0000, 32'shffff_ffff,
			32'sh8000_0000);

		// random; a calm stretch with no idling in the middle
		for (i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 600 && i < 700);
			k = $urandom_range(0, 19);
			op = (k == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
			a = pick_value();
			b = pick_denominator();
			c = pick_value();
			d = pick_denominator();
			// keep full-range raw bits flowing through both numerator fields
			if ($urandom_range(0, 15) == 0) begin
				a = $urandom();
				c = $urandom();
			end
			send_item(op, a, b, c, d);
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (fracs.pending() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("%0d items sent, %0d results checked, with error paths and overflow",
			items_sent, fracs.checked);
		$display("actions 0..7 seen %0d %0d %0d %0d %0d %0d %0d %0d",
			op_seen[0], op_seen[1], op_seen[2], op_seen[3],
			op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
		if (fracs.errors == 0 && fracs.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
